FILE: design/osd_pkg.sv
// Types, register indexes and colour class codes shared by the obstruction span detector.
`default_nettype none
package osd_pkg;

	// Fixed field widths
	localparam int unsigned ROW_W     = 11;
	localparam int unsigned COL_W     = 10;
	localparam int unsigned CARRIED   = 10;
	localparam int unsigned CLASS_W   = 3;
	localparam int unsigned CLASSES_W = CARRIED * CLASS_W;
	localparam int unsigned SCORE_W   = 8;
	localparam int unsigned CFG_W     = 11;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_WIDTH    = 3'd2;
	localparam logic [IDX_W-1:0] REG_FIELD_PEN    = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROBOT        = 3'd4;
	localparam logic [IDX_W-1:0] REG_UNCLASSIFIED = 3'd5;
	localparam logic [IDX_W-1:0] REG_BACKGROUND   = 3'd6;

	// Colour class codes
	localparam logic [CLASS_W-1:0] CLS_GREEN        = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_YELLOW       = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_WHITE        = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_BLUE         = 3'd3;
	localparam logic [CLASS_W-1:0] CLS_RED          = 3'd4;
	localparam logic [CLASS_W-1:0] CLS_UNCLASSIFIED = 3'd5;
	localparam logic [CLASS_W-1:0] CLS_BACKGROUND   = 3'd6;

	typedef struct packed {
		logic [ROW_W-1:0]     edge_row;
		logic [CLASSES_W-1:0] colour_classes;
	} col_item_t;

	typedef struct packed {
		logic [COL_W-1:0] start_col;
		logic [ROW_W-1:0] start_row;
		logic [COL_W-1:0] end_col;
		logic [ROW_W-1:0] end_row;
	} span_item_t;

	typedef struct packed {
		logic [CFG_W-1:0]  image_width;
		logic [CFG_W-1:0]  image_height;
		logic [CFG_W-1:0]  min_width;
		logic signed [3:0] field_penalty;
		logic [2:0]        robot_score;
		logic [2:0]        uncl_score;
		logic [2:0]        bg_score;
	} cfg_t;

	// Classified column travelling from front to back
	typedef struct packed {
		logic             obstruction;
		logic [ROW_W-1:0] edge_row;
	} col_class_t;

endpackage
`default_nettype wire

FILE: design/osd_front.sv
// Front end: scores the window below the field edge and classifies the column.
`default_nettype none
module osd_front import osd_pkg::*; #(
	parameter int unsigned WINDOW_ROWS = 10,
	parameter int unsigned MAX_HEIGHT  = 1024
) (
	input  wire col_item_t  col_item,
	input  wire cfg_t       cfg,
	output col_class_t      cls_out
);

	localparam int unsigned ROWS = (WINDOW_ROWS < CARRIED) ? WINDOW_ROWS : CARRIED;
	localparam int unsigned EXT_W = 13;

	logic [CFG_W-1:0] height_eff;

	always_comb begin
		if ({2'b00, cfg.image_height} > EXT_W'(MAX_HEIGHT))
			height_eff = CFG_W'(MAX_HEIGHT);
		else
			height_eff = cfg.image_height;
	end

	function automatic logic signed [SCORE_W-1:0] class_score(
		input logic [CLASS_W-1:0] cls,
		input cfg_t c
	);
		logic signed [SCORE_W-1:0] s;
		case (cls) inside
			CLS_GREEN, CLS_YELLOW:         s = SCORE_W'(c.field_penalty);
			CLS_WHITE, CLS_BLUE, CLS_RED:  s = SCORE_W'(c.robot_score);
			CLS_UNCLASSIFIED:              s = SCORE_W'(c.uncl_score);
			CLS_BACKGROUND:                s = SCORE_W'(c.bg_score);
			default:                       s = '0;
		endcase
		return s;
	endfunction

	logic signed [SCORE_W-1:0] score;

	// Sum the in-image window pixels
	always_comb begin
		logic [ROW_W:0] row;
		score = '0;
		for (int unsigned i = 0; i < ROWS; i++) begin
			row = {1'b0, col_item.edge_row} + (ROW_W+1)'(i);
			if (row < {1'b0, height_eff})
				score = score + class_score(col_item.colour_classes[CLASS_W*i +: CLASS_W], cfg);
		end
	end

	assign cls_out.obstruction = (score > 0);
	assign cls_out.edge_row    = col_item.edge_row;

endmodule
`default_nettype wire

FILE: design/osd_queue.sv
// Short queue of classified columns between front and back.
`default_nettype none
module osd_queue import osd_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  wire col_class_t push_data,
	input  wire             pop,
	output col_class_t      head,
	output logic            full,
	output logic            empty
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	col_class_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

FILE: design/osd_back.sv
// Back end: column counter, run tracker and registered result output.
`default_nettype none
module osd_back import osd_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire cfg_t       cfg,
	input  wire             q_empty,
	input  wire col_class_t q_head,
	output logic            q_pop,
	output logic            span_valid,
	input  wire             span_ready,
	output span_item_t      span_item
);

	localparam int unsigned EXT_W = 13;

	logic [CFG_W-1:0] width_eff;
	logic [COL_W-1:0] col_idx_q;
	logic             in_run_q;
	logic [ROW_W-1:0] run_len_q;
	logic [COL_W-1:0] run_start_col_q;
	logic [ROW_W-1:0] run_start_row_q;
	logic             out_valid_q;
	span_item_t       out_item_q;

	logic last;
	logic close_run;
	logic emit;

	always_comb begin
		if (cfg.image_width == '0)
			width_eff = CFG_W'(1);
		else if ({2'b00, cfg.image_width} > EXT_W'(MAX_WIDTH))
			width_eff = CFG_W'(MAX_WIDTH);
		else
			width_eff = cfg.image_width;
	end

	// Advance only when the output register can take a possible result
	assign q_pop     = !q_empty && (!out_valid_q || span_ready);
	assign last      = ({1'b0, col_idx_q} + CFG_W'(1)) >= width_eff;
	assign close_run = !q_head.obstruction || last;
	assign emit      = close_run && in_run_q && (run_len_q >= cfg.min_width);

	assign span_valid = out_valid_q;
	assign span_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_idx_q       <= '0;
			in_run_q        <= 1'b0;
			run_len_q       <= '0;
			run_start_col_q <= '0;
			run_start_row_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (q_pop) begin
				if (close_run) begin
					in_run_q  <= 1'b0;
					run_len_q <= '0;
				end else begin
					if (!in_run_q) begin
						run_start_col_q <= col_idx_q;
						run_start_row_q <= q_head.edge_row;
						in_run_q        <= 1'b1;
					end
					if (run_len_q != '1)
						run_len_q <= run_len_q + ROW_W'(1);
				end
				col_idx_q <= last ? '0 : col_idx_q + COL_W'(1);
			end
			if (q_pop && emit)
				out_valid_q <= 1'b1;
			else if (span_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_item_q.start_col <= run_start_col_q;
			out_item_q.start_row <= run_start_row_q;
			out_item_q.end_col   <= col_idx_q;
			out_item_q.end_row   <= q_head.edge_row;
		end
	end

endmodule
`default_nettype wire

FILE: design/obstruction_span_detector.sv
// Top level of the obstruction span detector: configuration registers, front, queue and back.
`default_nettype none
// One image column is taken per request on the col channel: its field-edge row and the
// colour classes of the pixels below it. The front scores the window in the same cycle it
// takes the column and writes the verdict into a two-entry queue; the back takes one queued
// column per cycle unless the span output is held, tracks runs of obstruction columns and
// places a finished span in an output register. Sustained rate is then one column per clock.
// col_ready drops only when the queue is full, which happens only while the span output is
// held by its consumer. Configuration writes take effect on the next clock; write them only
// between frames with the block idle.
module obstruction_span_detector import osd_pkg::*; #(
	parameter int unsigned WINDOW_ROWS = 10,
	parameter int unsigned MAX_WIDTH   = 1024,
	parameter int unsigned MAX_HEIGHT  = 1024
) (
	input  wire              clk,
	input  wire              arst_n,
	// Column requests
	input  wire              col_valid,
	output logic             col_ready,
	input  wire col_item_t   col_item,
	// Span results
	output logic             span_valid,
	input  wire              span_ready,
	output span_item_t       span_item,
	// Configuration writes
	input  wire              cfg_we,
	input  wire [IDX_W-1:0]  cfg_index,
	input  wire [CFG_W-1:0]  cfg_wdata
);

	cfg_t       cfg_q;
	col_class_t front_cls;
	col_class_t q_head;
	logic       q_full;
	logic       q_empty;
	logic       q_push;
	logic       q_pop;

	// Register file: hold reset defaults until written, drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= CFG_W'(1024);
			cfg_q.image_height  <= CFG_W'(1024);
			cfg_q.min_width     <= CFG_W'(3);
			cfg_q.field_penalty <= -4'sd3;
			cfg_q.robot_score   <= 3'd3;
			cfg_q.uncl_score    <= 3'd1;
			cfg_q.bg_score      <= 3'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width   <= cfg_wdata;
				REG_IMAGE_HEIGHT: cfg_q.image_height  <= cfg_wdata;
				REG_MIN_WIDTH:    cfg_q.min_width     <= cfg_wdata;
				REG_FIELD_PEN:    cfg_q.field_penalty <= cfg_wdata[3:0];
				REG_ROBOT:        cfg_q.robot_score   <= cfg_wdata[2:0];
				REG_UNCLASSIFIED: cfg_q.uncl_score    <= cfg_wdata[2:0];
				REG_BACKGROUND:   cfg_q.bg_score      <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// Accept a column whenever the queue has room
	assign col_ready = !q_full;
	assign q_push    = col_valid && col_ready;

	osd_front #(
		.WINDOW_ROWS (WINDOW_ROWS),
		.MAX_HEIGHT  (MAX_HEIGHT)
	) u_front (
		.col_item (col_item),
		.cfg      (cfg_q),
		.cls_out  (front_cls)
	);

	osd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_cls),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	osd_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.span_valid (span_valid),
		.span_ready (span_ready),
		.span_item  (span_item)
	);

endmodule
`default_nettype wire
